@@ hw/rtl/dltq_pkg.sv @@
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants of the delta-list timer queue
// item layouts, operation and result codes, fixed field widths
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int TIME_W = 32;
  localparam int GRAN_W = 16;
  localparam int TAG_W  = 8;
  localparam int KIND_W = 3;
  localparam int FUNC_W = 2;

  // results of one pop item are capped
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RESULTS);

  // remainder unit: one dividend bit per cycle over time plus delay
  localparam int DIV_W  = TIME_W + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DIV_W);

  localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP      = 2'd2;

  localparam logic [KIND_W-1:0] KIND_REGISTERED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POOL_FULL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NOT_DUE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HEAD_DUE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUE_TASK   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE_DUE   = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] current_time;
    logic [TIME_W-1:0] delay;
    logic [TAG_W-1:0]  task_tag;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  due_tag;
    logic              last;
  } out_item_t;

endpackage

@@ hw/rtl/delta_list_timer_queue_top.sv @@
// ----------------------------------------------------------------------------
// delta_list_timer_queue_top: delta-list timer queue over a fixed entry pool
// register, tick and pop items on a valid/ready channel, one result register
// ----------------------------------------------------------------------------
// one item at a time; in_ready is high only while the sequencer is idle, and
// the next item may enter while the last result still waits in the output
// register. a register item makes two passes of the shared remainder unit,
// which rounds the deadline to the tick granularity, then one memory read
// per list entry passed in the walk (up to POOL_DEPTH entries). a tick item
// makes one remainder pass on the current time; a pop item unlinks the due
// tasks from the head of the list. the entry stores are undefined until
// written, so there is no clearing pass after reset. a granularity of zero
// behaves as one
module delta_list_timer_queue_top #(
  parameter int POOL_DEPTH = 16,
  parameter int TAG_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dltq_pkg::in_item_t            in_data,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output dltq_pkg::out_item_t           out_data,
  // tick granularity register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dltq_pkg::GRAN_W-1:0]   cfg_data
);

  // entry index carries a null code one above the last entry
  localparam int IDX_W = $clog2(POOL_DEPTH + 1);
  localparam int AW    = $clog2(POOL_DEPTH);
  localparam int TW    = (TAG_BITS < dltq_pkg::TAG_W) ? TAG_BITS : dltq_pkg::TAG_W;
  localparam int TM    = dltq_pkg::TIME_W;
  localparam int GW    = dltq_pkg::GRAN_W;
  localparam int CW    = dltq_pkg::CNT_W;
  localparam int DW    = dltq_pkg::DIV_W;
  localparam int DCW   = dltq_pkg::DCNT_W;
  localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_DEPTH);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_ALLOC    = 15'h0002,
    S_DIV      = 15'h0004,
    S_CALC     = 15'h0008,
    S_SAT      = 15'h0010,
    S_WALK     = 15'h0020,
    S_SUCC_RD  = 15'h0040,
    S_SUCC     = 15'h0080,
    S_WR_E     = 15'h0100,
    S_LINK     = 15'h0200,
    S_TICK     = 15'h0400,
    S_TICK_UPD = 15'h0800,
    S_POP_HEAD = 15'h1000,
    S_POP_TEST = 15'h2000,
    S_EMIT     = 15'h4000
  } state_t;

  // entry stores
  logic [TM-1:0]       delta_mem [POOL_DEPTH];
  logic [TAG_BITS-1:0] tag_mem   [POOL_DEPTH];
  logic [IDX_W-1:0]    link_mem  [POOL_DEPTH];

  logic [TM-1:0]       delta_rd_r;
  logic [TAG_BITS-1:0] tag_rd_r;
  logic [IDX_W-1:0]    link_rd_r;

  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic                we_delta, we_tag, we_link;
  logic [TM-1:0]       wd_delta;
  logic [IDX_W-1:0]    wd_link;

  // control state
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0]    free_r, free_nxt;
  logic [IDX_W-1:0]    fresh_r, fresh_nxt;
  logic [GW-1:0]       gran_r;
  logic                out_valid_r, out_valid_nxt;
  logic                pend_valid_r, pend_valid_nxt;

  // working registers of the current item
  logic [dltq_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [TM-1:0]       now_r, now_nxt;
  logic [DW-1:0]       sum_r, sum_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [IDX_W-1:0]    e_r, e_nxt;
  logic [IDX_W-1:0]    pred_r, pred_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [IDX_W-1:0]    n_r, n_nxt;
  logic [TM-1:0]       rem_r, rem_nxt;
  logic [DW:0]         calc_r, calc_nxt;
  logic [TM-1:0]       base_r, base_nxt;
  logic [GW-1:0]       mod_s_r, mod_s_nxt;
  logic [GW-1:0]       mod_now_r, mod_now_nxt;
  logic [GW-1:0]       div_acc_r, div_acc_nxt;
  logic [DW-1:0]       div_dvd_r, div_dvd_nxt;
  logic [DCW-1:0]      div_cnt_r, div_cnt_nxt;
  logic                div_pass_r, div_pass_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [TAG_BITS-1:0] pend_tag_r, pend_tag_nxt;
  logic [dltq_pkg::KIND_W-1:0] em_kind_r, em_kind_nxt;
  logic [dltq_pkg::TAG_W-1:0]  em_tag_r, em_tag_nxt;
  logic                em_last_r, em_last_nxt;
  dltq_pkg::out_item_t out_data_r, out_data_nxt;

  // shared remainder step
  logic [GW-1:0]       g;
  logic [GW:0]         div_t;
  logic [GW:0]         div_diff;
  logic [GW-1:0]       div_acc_step;

  // scratch arithmetic
  logic [GW-1:0]       adj_s;
  logic [DW:0]         iv_wide;
  logic [TM-1:0]       iv_sat;
  logic [TM-1:0]       succ_delta;
  logic [TM-1:0]       tick_delta;
  logic [IDX_W-1:0]    link_clean;
  logic [IDX_W-1:0]    head_clean;
  logic                in_fire;
  logic                slot_free;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return idx < NIL;
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;

  // zero granularity behaves as one
  assign g = (gran_r == '0) ? GW'(1) : gran_r;

  // restoring remainder, one dividend bit a cycle
  assign div_t        = {div_acc_r, div_dvd_r[DW-1]};
  assign div_diff     = div_t - {1'b0, g};
  assign div_acc_step = (div_t >= {1'b0, g}) ? div_diff[GW-1:0] : div_t[GW-1:0];

  // deadline rounded up, less the current time rounded down
  assign adj_s   = (mod_s_r == '0) ? '0 : (g - mod_s_r);
  assign iv_wide = calc_r - (DW + 1)'(base_r);
  assign iv_sat  = (iv_wide[DW:TM] != '0) ? '1 : iv_wide[TM-1:0];

  assign succ_delta = (delta_rd_r > rem_r) ? (delta_rd_r - rem_r) : '0;
  assign tick_delta = (delta_rd_r > TM'(g)) ? (delta_rd_r - TM'(g)) : '0;
  assign link_clean = idx_ok(link_rd_r) ? link_rd_r : NIL;
  assign head_clean = idx_ok(head_r) ? head_r : NIL;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    free_nxt       = free_r;
    fresh_nxt      = fresh_r;
    pend_valid_nxt = pend_valid_r;
    func_nxt       = func_r;
    now_nxt        = now_r;
    sum_nxt        = sum_r;
    tag_nxt        = tag_r;
    e_nxt          = e_r;
    pred_nxt       = pred_r;
    cur_nxt        = cur_r;
    n_nxt          = n_r;
    rem_nxt        = rem_r;
    calc_nxt       = calc_r;
    base_nxt       = base_r;
    mod_s_nxt      = mod_s_r;
    mod_now_nxt    = mod_now_r;
    div_acc_nxt    = div_acc_r;
    div_dvd_nxt    = div_dvd_r;
    div_cnt_nxt    = div_cnt_r;
    div_pass_nxt   = div_pass_r;
    count_nxt      = count_r;
    pend_tag_nxt   = pend_tag_r;
    em_kind_nxt    = em_kind_r;
    em_tag_nxt     = em_tag_r;
    em_last_nxt    = em_last_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    rd_addr  = cur_r;
    wr_addr  = e_r;
    we_delta = 1'b0;
    we_tag   = 1'b0;
    we_link  = 1'b0;
    wd_delta = rem_r;
    wd_link  = cur_r;

    unique case (state_r)
      S_IDLE: begin
        // link of the free head is read ahead for allocation
        rd_addr = free_r;
        if (in_fire) begin
          func_nxt     = in_data.func;
          now_nxt      = in_data.current_time;
          sum_nxt      = DW'(in_data.current_time) + DW'(in_data.delay);
          tag_nxt      = TAG_BITS'(in_data.task_tag[TW-1:0]);
          div_acc_nxt  = '0;
          div_cnt_nxt  = dltq_pkg::DIV_STEPS;
          case (in_data.func)
            dltq_pkg::FUNC_REGISTER: begin
              div_dvd_nxt  = DW'(in_data.current_time) + DW'(in_data.delay);
              div_pass_nxt = 1'b0;
              if (idx_ok(free_r)) begin
                state_nxt = S_ALLOC;
              end else if (fresh_r < NIL) begin
                e_nxt     = fresh_r;
                fresh_nxt = fresh_r + IDX_W'(1);
                state_nxt = S_DIV;
              end else begin
                em_kind_nxt = dltq_pkg::KIND_POOL_FULL;
                em_tag_nxt  = '0;
                em_last_nxt = 1'b1;
                state_nxt   = S_EMIT;
              end
            end
            dltq_pkg::FUNC_TICK: begin
              div_dvd_nxt  = DW'(in_data.current_time);
              div_pass_nxt = 1'b1;
              state_nxt    = S_DIV;
            end
            dltq_pkg::FUNC_POP: begin
              count_nxt      = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_POP_HEAD;
            end
            default: begin
              // unused selector: item dropped without a result
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ALLOC: begin
        e_nxt     = free_r;
        free_nxt  = link_clean;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        div_acc_nxt = div_acc_step;
        div_dvd_nxt = {div_dvd_r[DW-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r - DCW'(1);
        if (div_cnt_r == DCW'(1)) begin
          if (!div_pass_r) begin
            // second pass: current time
            mod_s_nxt    = div_acc_step;
            div_acc_nxt  = '0;
            div_dvd_nxt  = DW'(now_r);
            div_cnt_nxt  = dltq_pkg::DIV_STEPS;
            div_pass_nxt = 1'b1;
          end else begin
            mod_now_nxt = div_acc_step;
            state_nxt   = (func_r == dltq_pkg::FUNC_TICK) ? S_TICK : S_CALC;
          end
        end
      end

      S_CALC: begin
        calc_nxt  = (DW + 1)'(sum_r) + (DW + 1)'(adj_s);
        base_nxt  = now_r - TM'(mod_now_r);
        state_nxt = S_SAT;
      end

      S_SAT: begin
        // start of the walk at the list head
        rem_nxt  = iv_sat;
        pred_nxt = NIL;
        cur_nxt  = head_clean;
        n_nxt    = '0;
        rd_addr  = head_r;
        state_nxt = idx_ok(head_r) ? S_WALK : S_WR_E;
      end

      S_WALK: begin
        if (delta_rd_r <= rem_r) begin
          rem_nxt  = rem_r - delta_rd_r;
          pred_nxt = cur_r;
          cur_nxt  = link_clean;
          n_nxt    = n_r + IDX_W'(1);
          rd_addr  = link_rd_r;
          if (idx_ok(link_rd_r) && ((n_r + IDX_W'(1)) < NIL)) begin
            state_nxt = S_WALK;
          end else if (idx_ok(link_rd_r)) begin
            state_nxt = S_SUCC_RD;
          end else begin
            state_nxt = S_WR_E;
          end
        end else begin
          state_nxt = S_SUCC_RD;
        end
      end

      S_SUCC_RD: begin
        rd_addr   = cur_r;
        state_nxt = S_SUCC;
      end

      S_SUCC: begin
        // successor keeps its deadline: its delta drops by the new entry's
        we_delta  = 1'b1;
        wr_addr   = cur_r;
        wd_delta  = succ_delta;
        state_nxt = S_WR_E;
      end

      S_WR_E: begin
        we_delta  = 1'b1;
        we_tag    = 1'b1;
        we_link   = 1'b1;
        wr_addr   = e_r;
        wd_delta  = rem_r;
        wd_link   = cur_r;
        state_nxt = S_LINK;
      end

      S_LINK: begin
        if (idx_ok(pred_r)) begin
          we_link = 1'b1;
          wr_addr = pred_r;
          wd_link = e_r;
        end else begin
          head_nxt = e_r;
        end
        em_kind_nxt = dltq_pkg::KIND_REGISTERED;
        em_tag_nxt  = '0;
        em_last_nxt = 1'b1;
        state_nxt   = S_EMIT;
      end

      S_TICK: begin
        rd_addr = head_r;
        if ((mod_now_r == '0) && idx_ok(head_r)) begin
          state_nxt = S_TICK_UPD;
        end else begin
          em_kind_nxt = dltq_pkg::KIND_NOT_DUE;
          em_tag_nxt  = '0;
          em_last_nxt = 1'b1;
          state_nxt   = S_EMIT;
        end
      end

      S_TICK_UPD: begin
        we_delta    = 1'b1;
        wr_addr     = head_r;
        wd_delta    = tick_delta;
        em_kind_nxt = (tick_delta == '0) ? dltq_pkg::KIND_HEAD_DUE
                                         : dltq_pkg::KIND_NOT_DUE;
        em_tag_nxt  = '0;
        em_last_nxt = 1'b1;
        state_nxt   = S_EMIT;
      end

      S_POP_HEAD: begin
        rd_addr = head_r;
        if ((count_r == dltq_pkg::MAX_CNT) || !idx_ok(head_r)) begin
          em_kind_nxt = pend_valid_r ? dltq_pkg::KIND_DUE_TASK
                                     : dltq_pkg::KIND_NONE_DUE;
          em_tag_nxt  = pend_valid_r ? dltq_pkg::TAG_W'(pend_tag_r[TW-1:0]) : '0;
          em_last_nxt = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          state_nxt = S_POP_TEST;
        end
      end

      S_POP_TEST: begin
        if (delta_rd_r != '0) begin
          em_kind_nxt = pend_valid_r ? dltq_pkg::KIND_DUE_TASK
                                     : dltq_pkg::KIND_NONE_DUE;
          em_tag_nxt  = pend_valid_r ? dltq_pkg::TAG_W'(pend_tag_r[TW-1:0]) : '0;
          em_last_nxt = 1'b1;
          state_nxt   = S_EMIT;
        end else if (pend_valid_r) begin
          // another due task follows: the held one is not the last
          em_kind_nxt = dltq_pkg::KIND_DUE_TASK;
          em_tag_nxt  = dltq_pkg::TAG_W'(pend_tag_r[TW-1:0]);
          em_last_nxt = 1'b0;
          state_nxt   = S_EMIT;
        end else begin
          // unlink the head and push it onto the free list
          head_nxt       = link_clean;
          free_nxt       = head_r;
          we_link        = 1'b1;
          wr_addr        = head_r;
          wd_link        = free_r;
          pend_tag_nxt   = tag_rd_r;
          pend_valid_nxt = 1'b1;
          count_nxt      = count_r + CW'(1);
          state_nxt      = S_POP_HEAD;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.kind    = em_kind_r;
          out_data_nxt.due_tag = em_tag_r;
          out_data_nxt.last    = em_last_r;
          pend_valid_nxt       = 1'b0;
          state_nxt            = em_last_r ? S_IDLE : S_POP_HEAD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // entry stores, registered read
  always_ff @(posedge clk) begin
    if (we_delta) begin
      delta_mem[wr_addr[AW-1:0]] <= wd_delta;
    end
    delta_rd_r <= delta_mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_tag) begin
      tag_mem[wr_addr[AW-1:0]] <= tag_r;
    end
    tag_rd_r <= tag_mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_link) begin
      link_mem[wr_addr[AW-1:0]] <= wd_link;
    end
    link_rd_r <= link_mem[rd_addr[AW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= NIL;
      free_r       <= NIL;
      fresh_r      <= '0;
      gran_r       <= GW'(10);
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      free_r       <= free_nxt;
      fresh_r      <= fresh_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_valid) begin
        gran_r <= cfg_data;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    now_r      <= now_nxt;
    sum_r      <= sum_nxt;
    tag_r      <= tag_nxt;
    e_r        <= e_nxt;
    pred_r     <= pred_nxt;
    cur_r      <= cur_nxt;
    n_r        <= n_nxt;
    rem_r      <= rem_nxt;
    calc_r     <= calc_nxt;
    base_r     <= base_nxt;
    mod_s_r    <= mod_s_nxt;
    mod_now_r  <= mod_now_nxt;
    div_acc_r  <= div_acc_nxt;
    div_dvd_r  <= div_dvd_nxt;
    div_cnt_r  <= div_cnt_nxt;
    div_pass_r <= div_pass_nxt;
    count_r    <= count_nxt;
    pend_tag_r <= pend_tag_nxt;
    em_kind_r  <= em_kind_nxt;
    em_tag_r   <= em_tag_nxt;
    em_last_r  <= em_last_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
